@@ hw/rtl/irafp_pkg.sv @@
// Package for the IMU rate/angle frame parser.
// Holds the deframer phase type, the result item type, register indexes and scaling helpers.
// No dependencies.
package irafp_pkg;

    localparam int PAYLOAD_BYTES = 6;
    localparam int FILL_W        = $clog2(PAYLOAD_BYTES + 1);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CFG_HEADER     = 2'd0;
    localparam logic [1:0] CFG_RATE_TYPE  = 2'd1;
    localparam logic [1:0] CFG_ANGLE_TYPE = 2'd2;

    localparam logic [7:0] HEADER_RESET     = 8'd85;
    localparam logic [7:0] RATE_TYPE_RESET  = 8'd82;
    localparam logic [7:0] ANGLE_TYPE_RESET = 8'd83;

    localparam logic KIND_RATE  = 1'b0;
    localparam logic KIND_ANGLE = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_TYPE   = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    // Three little-endian signed words of a finished frame
    typedef struct packed {
        logic               done;
        logic signed [15:0] raw_first;
        logic signed [15:0] raw_second;
        logic signed [15:0] raw_third;
    } frame_t;

    typedef struct packed {
        logic               frame_kind;
        logic signed [22:0] axis_first;
        logic signed [22:0] axis_second;
        logic signed [22:0] axis_third;
        logic signed [21:0] start_yaw;
        logic               last_of_run;
    } result_t;

    // raw * 125, 11 fraction bits
    function automatic logic signed [22:0] scale_rate(input logic signed [15:0] raw);
        logic signed [22:0] w;
        w = 23'(raw);
        return w * 23'sd125;
    endfunction

    // raw * 45, 13 fraction bits
    function automatic logic signed [21:0] scale_angle(input logic signed [15:0] raw);
        logic signed [21:0] w;
        w = 22'(raw);
        return w * 22'sd45;
    endfunction

endpackage

@@ hw/rtl/irafp_channels.sv @@
// Valid/ready channel interfaces of the IMU rate/angle frame parser.
// No dependencies.
interface irafp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface irafp_result_if;
    logic               valid;
    logic               ready;
    logic               frame_kind;
    logic signed [22:0] axis_first;
    logic signed [22:0] axis_second;
    logic signed [22:0] axis_third;
    logic signed [21:0] start_yaw;
    logic               last_of_run;

    modport source (output valid, output frame_kind, output axis_first, output axis_second,
                    output axis_third, output start_yaw, output last_of_run, input ready);
    modport sink   (input valid, input frame_kind, input axis_first, input axis_second,
                    input axis_third, input start_yaw, input last_of_run, output ready);
endinterface

@@ hw/rtl/irafp_deframer.sv @@
// One deframer: header byte, type byte, then six payload bytes.
// Depends on irafp_pkg for phase_t and frame_t.
module irafp_deframer
    import irafp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  logic [7:0]   rx_byte,
    input  logic [7:0]   header_byte,
    input  logic [7:0]   type_byte,
    output frame_t       frame
);

    phase_t              phase_reg, phase_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [7:0]          bytes_reg [PAYLOAD_BYTES];
    logic                store;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        store      = 1'b0;
        case (phase_reg)
            PH_TYPE:
            begin
                if (rx_byte == type_byte)
                begin
                    phase_next = PH_DATA;
                    fill_next  = '0;
                end
                else
                begin
                    phase_next = PH_HEADER;
                end
            end
            PH_DATA:
            begin
                if (fill_reg < FILL_W'(PAYLOAD_BYTES))
                begin
                    store     = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                if (fill_next >= FILL_W'(PAYLOAD_BYTES))
                    phase_next = PH_HEADER;
            end
            default:
            begin
                // unused code counts as waiting for a header
                phase_next = (rx_byte == header_byte) ? PH_TYPE : PH_HEADER;
            end
        endcase
    end

    // outputs: the last payload byte is the one arriving now
    always_comb
    begin
        frame.done       = take && (phase_reg == PH_DATA)
                           && (fill_reg == FILL_W'(PAYLOAD_BYTES - 1));
        frame.raw_first  = {bytes_reg[1], bytes_reg[0]};
        frame.raw_second = {bytes_reg[3], bytes_reg[2]};
        frame.raw_third  = {rx_byte, bytes_reg[4]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            fill_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && store)
            bytes_reg[fill_reg] <= rx_byte;
    end

endmodule

@@ hw/rtl/imu_rate_angle_frame_parser.sv @@
// IMU rate/angle frame parser: two deframers on one byte stream feeding a result queue.
// A result is written to the queue when the byte that completes its frame is accepted.
// Throughput: one byte per cycle; results drain one per cycle from a four-entry queue, and
// ready is low while fewer than two queue slots are free (a byte may cause two results).
// Reset: both deframers wait for a header, start yaw uncaptured, queue empty,
// registers 85/82/83.
module imu_rate_angle_frame_parser
    import irafp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    irafp_byte_if.sink   rx,
    irafp_result_if.source res
);

    logic [7:0]          header_reg, rate_type_reg, angle_type_reg;
    logic [15:0]         yaw_raw_reg, yaw_raw_next;
    result_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                take, pop;
    frame_t              rate_frame, angle_frame;
    result_t             rate_res, angle_res, entry0, entry1;
    logic                push0, push1;
    logic signed [21:0]  start_yaw;

    assign rx.ready = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign take     = rx.valid && rx.ready;
    assign pop      = res.valid && res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg     <= HEADER_RESET;
            rate_type_reg  <= RATE_TYPE_RESET;
            angle_type_reg <= ANGLE_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER:     header_reg     <= cfg_data;
                CFG_RATE_TYPE:  rate_type_reg  <= cfg_data;
                CFG_ANGLE_TYPE: angle_type_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    irafp_deframer u_rate (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .rx_byte     (rx.rx_byte),
        .header_byte (header_reg),
        .type_byte   (rate_type_reg),
        .frame       (rate_frame)
    );

    irafp_deframer u_angle (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .rx_byte     (rx.rx_byte),
        .header_byte (header_reg),
        .type_byte   (angle_type_reg),
        .frame       (angle_frame)
    );

    // latch the first nonzero yaw; a zero latch means not captured yet
    always_comb
    begin
        yaw_raw_next = yaw_raw_reg;
        if (angle_frame.done && (yaw_raw_reg == 16'd0))
            yaw_raw_next = angle_frame.raw_third;
    end

    assign start_yaw = scale_angle(yaw_raw_next);

    always_comb
    begin
        rate_res.frame_kind   = KIND_RATE;
        rate_res.axis_first   = scale_rate(rate_frame.raw_first);
        rate_res.axis_second  = scale_rate(rate_frame.raw_second);
        rate_res.axis_third   = scale_rate(rate_frame.raw_third);
        rate_res.start_yaw    = start_yaw;
        rate_res.last_of_run  = !angle_frame.done;

        angle_res.frame_kind  = KIND_ANGLE;
        angle_res.axis_first  = 23'(scale_angle(angle_frame.raw_first));
        angle_res.axis_second = 23'(scale_angle(angle_frame.raw_second));
        angle_res.axis_third  = 23'(scale_angle(angle_frame.raw_third));
        angle_res.start_yaw   = start_yaw;
        angle_res.last_of_run = 1'b1;

        // rate result goes first when both frames end on this byte
        push0  = rate_frame.done || angle_frame.done;
        push1  = rate_frame.done && angle_frame.done;
        entry0 = rate_frame.done ? rate_res : angle_res;
        entry1 = angle_res;

        count_next = count_reg + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_raw_reg <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            yaw_raw_reg <= yaw_raw_next;
            wr_ptr_reg  <= wr_ptr_reg + QPTR_W'(push0) + QPTR_W'(push1);
            rd_ptr_reg  <= rd_ptr_reg + QPTR_W'(pop);
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
            queue_reg[wr_ptr_reg] <= entry0;
        if (push1)
            queue_reg[wr_ptr_reg + 1'b1] <= entry1;
    end

    assign res.valid       = (count_reg != '0);
    assign res.frame_kind  = queue_reg[rd_ptr_reg].frame_kind;
    assign res.axis_first  = queue_reg[rd_ptr_reg].axis_first;
    assign res.axis_second = queue_reg[rd_ptr_reg].axis_second;
    assign res.axis_third  = queue_reg[rd_ptr_reg].axis_third;
    assign res.start_yaw   = queue_reg[rd_ptr_reg].start_yaw;
    assign res.last_of_run = queue_reg[rd_ptr_reg].last_of_run;

endmodule
